>>> hw/rtl/smq_pkg.sv
`timescale 1ns / 1ps

package smq_pkg;

    // pool and queue counts
    localparam int ENTRIES = 16;
    localparam int QUEUES  = 4;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int QID_W    = 2;
    localparam int STATUS_W = 2;

    // derived widths: a link can also hold the null code
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int LINK_W = $clog2(ENTRIES + 1);
    localparam int QSEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

    localparam logic [DATA_W-1:0] EMPTY_DATA = {DATA_W{1'b1}};

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // request bundle from the control into the link store
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              alloc;
        logic [IDX_W-1:0]  alloc_addr;
    } link_req_t;

    function automatic logic is_entry(input logic [LINK_W-1:0] link);
        return link < LINK_W'(ENTRIES);
    endfunction

endpackage

>>> hw/rtl/smq_ram.sv
`timescale 1ns / 1ps

module smq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/smq_link_store.sv
`timescale 1ns / 1ps

module smq_link_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  smq_pkg::link_req_t        req,
    output logic [smq_pkg::LINK_W-1:0] link_out
);

    import smq_pkg::*;

    // entries at or above the fill mark were never allocated and still
    // hold their reset link (next entry, null for the last one)
    logic [LINK_W-1:0] fill_reg;
    logic [LINK_W-1:0] fill_next;
    logic              fresh_reg;
    logic [LINK_W-1:0] fresh_link_reg;
    logic [LINK_W-1:0] mem_link;

    smq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (mem_link)
    );

    always_comb begin
        fill_next = fill_reg;
        if (req.alloc && (LINK_W'(req.alloc_addr) == fill_reg)) begin
            fill_next = fill_reg + LINK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
        if (req.rd_en) begin
            fresh_reg      <= LINK_W'(req.rd_addr) >= fill_reg;
            fresh_link_reg <= LINK_W'(req.rd_addr) + LINK_W'(1);
        end
    end

    // a stored link that is not an entry is taken as null
    always_comb begin
        if (fresh_reg) begin
            link_out = fresh_link_reg;
        end else if (is_entry(mem_link)) begin
            link_out = mem_link;
        end else begin
            link_out = NULL_LINK;
        end
    end

endmodule

>>> hw/rtl/shared_buffer_multi_queue.sv
`timescale 1ns / 1ps

// Shared-buffer multi-queue: QUEUES fifo queues share one pool of ENTRIES
// data entries, chained through a link store, with the unused entries kept
// on a free list that behaves as a stack. An enqueue word takes the entry at
// the head of the free list, stores its value and appends it to the chosen
// queue (status full, data 0, and no change if no entry is free). A dequeue
// word unlinks the head entry of the chosen queue, returns its value and
// pushes the entry back on the free list (status empty, data -1, and no
// change if the queue is empty). Every word gives exactly one result word.
// The accept edge launches the reads of the link memory and the value
// memory; the write-back edge writes back the pointers and loads the
// result register. The next word is taken the cycle after write-back,
// even while the result still waits on m_ready; a result that is not taken
// before the following word finishes holds that word in its write-back
// cycle. No clearing pass is needed after reset: a fill mark in the link
// store stands in for the initial free-list chain.
module shared_buffer_multi_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [smq_pkg::QID_W-1:0]          s_queue_id,
    input  logic signed [smq_pkg::DATA_W-1:0]  s_value,
    // result words
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [smq_pkg::DATA_W-1:0]  m_data,
    output logic [smq_pkg::STATUS_W-1:0]       m_status
);

    import smq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;

    // pointer registers
    logic [LINK_W-1:0] free_head_reg;
    logic [LINK_W-1:0] heads_reg [QUEUES];
    logic [IDX_W-1:0]  tails_reg [QUEUES];

    // word captured at accept
    opcode_t           op_reg;
    logic [QSEL_W-1:0] qsel_reg;
    logic [DATA_W-1:0] val_reg;
    logic              ok_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              head_null_reg;
    logic [IDX_W-1:0]  tail_reg;

    // result register
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_data_reg;
    status_t             m_status_reg;

    // accept-side decode
    logic              accept;
    logic [QSEL_W-1:0] qsel_in;
    logic              q_ok_in;
    logic [LINK_W-1:0] head_in;
    logic [IDX_W-1:0]  rd_idx;
    logic              ok_in;

    // write-back side
    logic              out_free;
    logic              commit;
    logic [LINK_W-1:0] link_out;
    logic [DATA_W-1:0] value_out;
    link_req_t         link_req;
    logic              val_wr_en;
    logic [LINK_W-1:0] deq_new_head;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_EXEC) && out_free;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;

    // queue numbers of QUEUES or more are rejected like full or empty queues
    assign qsel_in = QSEL_W'(s_queue_id);
    assign q_ok_in = {{(32 - QID_W){1'b0}}, s_queue_id} < 32'(QUEUES);
    assign head_in = heads_reg[qsel_in];

    always_comb begin
        if (opcode_t'(s_opcode) == OP_ENQ) begin
            rd_idx = free_head_reg[IDX_W-1:0];
            ok_in  = q_ok_in && is_entry(free_head_reg);
        end else begin
            rd_idx = head_in[IDX_W-1:0];
            ok_in  = q_ok_in && is_entry(head_in);
        end
    end

    // enqueue links the old tail to the new entry, unless the queue was
    // empty; dequeue links the freed entry onto the free list
    always_comb begin
        link_req.rd_en      = accept;
        link_req.rd_addr    = rd_idx;
        link_req.wr_en      = commit && ok_reg && ((op_reg == OP_DEQ) || !head_null_reg);
        link_req.wr_addr    = (op_reg == OP_ENQ) ? tail_reg : idx_reg;
        link_req.wr_data    = (op_reg == OP_ENQ) ? LINK_W'(idx_reg) : free_head_reg;
        link_req.alloc      = commit && ok_reg && (op_reg == OP_ENQ);
        link_req.alloc_addr = idx_reg;
    end

    assign val_wr_en = commit && ok_reg && (op_reg == OP_ENQ);

    // the tail entry's link is never written on enqueue, so the last
    // entry of a queue is recognized by comparing with the tail
    assign deq_new_head = (idx_reg == tail_reg) ? NULL_LINK : link_out;

    smq_link_store u_link_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (link_req),
        .link_out (link_out)
    );

    smq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_wr_en),
        .wr_addr (idx_reg),
        .wr_data (val_reg),
        .rd_en   (accept),
        .rd_addr (rd_idx),
        .rd_data (value_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < QUEUES; i++) begin
                heads_reg[i] <= NULL_LINK;
            end
        end else begin
            if (m_valid_reg && m_ready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b1;
                        if (ok_reg && (op_reg == OP_ENQ)) begin
                            free_head_reg <= link_out;
                            if (head_null_reg) begin
                                heads_reg[qsel_reg] <= LINK_W'(idx_reg);
                            end
                        end else if (ok_reg) begin
                            heads_reg[qsel_reg] <= deq_new_head;
                            free_head_reg       <= LINK_W'(idx_reg);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end

        // payload, no reset needed
        if (accept) begin
            op_reg        <= opcode_t'(s_opcode);
            qsel_reg      <= qsel_in;
            val_reg       <= s_value;
            ok_reg        <= ok_in;
            idx_reg       <= rd_idx;
            head_null_reg <= !is_entry(head_in);
            tail_reg      <= tails_reg[qsel_in];
        end
        if (commit) begin
            if (op_reg == OP_ENQ) begin
                m_data_reg   <= '0;
                m_status_reg <= ok_reg ? STATUS_OK : STATUS_FULL;
                if (ok_reg) begin
                    tails_reg[qsel_reg] <= idx_reg;
                end
            end else begin
                m_data_reg   <= ok_reg ? value_out : EMPTY_DATA;
                m_status_reg <= ok_reg ? STATUS_OK : STATUS_EMPTY;
            end
        end
    end

`ifndef SYNTHESIS
    // one word in flight: nothing is taken during write-back
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("word accepted during write-back");

    // an empty result always carries all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_EMPTY)) |-> (m_data == EMPTY_DATA))
        else $error("empty result with wrong data");

    // free-list head is an entry or null
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= NULL_LINK)
        else $error("free-list head out of range");

    // a held result stays put until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data) && $stable(m_status)))
        else $error("result changed while stalled");
`endif

endmodule

>>> tb/tb_shared_buffer_multi_queue.sv
`timescale 1ns / 1ps

module tb_shared_buffer_multi_queue;
    import smq_pkg::*;

    // run length and watchdog
    localparam int RANDOM_WORDS  = 1125;
    localparam int MAX_GAP       = 14;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_PRINTED   = 40;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
    } result_t;

    // one row of the directed table; typed rows carry their own result
    typedef struct {
        opcode_t                  op;
        logic [QID_W-1:0]         qid;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        result_t                  want;
    } stim_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_opcode;
    logic [QID_W-1:0]            s_queue_id;
    logic signed [DATA_W-1:0]    s_value;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [DATA_W-1:0]    m_data;
    logic [STATUS_W-1:0]         m_status;

    shared_buffer_multi_queue u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_queue_id (s_queue_id),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .m_status   (m_status)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // shadow copy of the pool, the links, the queue pointers and the free list
    logic [DATA_W-1:0] pool_value [ENTRIES];
    logic [LINK_W-1:0] pool_link  [ENTRIES];
    logic [LINK_W-1:0] q_head     [QUEUES];
    logic [LINK_W-1:0] q_tail     [QUEUES];
    logic [LINK_W-1:0] free_top;

    // results still owed by the block, oldest first
    result_t   pending_results [$];
    stim_row_t directed_rows [$];

    int error_count;
    int n_results;
    int n_ok;
    int n_full;
    int n_empty;
    int n_enq_sent;
    int n_deq_sent;
    bit long_hold_done;
    int idle_cycles;

    // applies one word to the shadow state and returns the result it gives
    function automatic result_t predict_queue_op(input opcode_t op,
                                                 input logic [QID_W-1:0] qid,
                                                 input logic [DATA_W-1:0] val);
        result_t           r;
        logic [IDX_W-1:0]  slot;
        logic [LINK_W-1:0] nxt;
        r.data   = '0;
        r.status = STATUS_OK;
        if (op == OP_ENQ) begin
            if (int'(qid) >= QUEUES || free_top >= LINK_W'(ENTRIES)) begin
                r.status = STATUS_FULL;
            end else begin
                // pop the free stack, then append the entry to the queue tail
                slot     = free_top[IDX_W-1:0];
                nxt      = pool_link[slot];
                free_top = (nxt < LINK_W'(ENTRIES)) ? nxt : NULL_LINK;
                if (q_head[qid] >= LINK_W'(ENTRIES)) begin
                    q_head[qid] = LINK_W'(slot);
                end else if (q_tail[qid] < LINK_W'(ENTRIES)) begin
                    pool_link[q_tail[qid][IDX_W-1:0]] = LINK_W'(slot);
                end
                q_tail[qid]      = LINK_W'(slot);
                pool_link[slot]  = NULL_LINK;
                pool_value[slot] = val;
            end
        end else begin
            if (int'(qid) >= QUEUES || q_head[qid] >= LINK_W'(ENTRIES)) begin
                r.data   = EMPTY_DATA;
                r.status = STATUS_EMPTY;
            end else begin
                // unlink the head entry and push it back on the free stack
                slot            = q_head[qid][IDX_W-1:0];
                nxt             = pool_link[slot];
                q_head[qid]     = (nxt < LINK_W'(ENTRIES)) ? nxt : NULL_LINK;
                pool_link[slot] = free_top;
                free_top        = LINK_W'(slot);
                r.data          = pool_value[slot];
            end
        end
        return r;
    endfunction

    function automatic void add_row(input opcode_t op, input logic [QID_W-1:0] qid,
                                    input logic [DATA_W-1:0] val, input bit typed,
                                    input logic [DATA_W-1:0] wdata, input status_t wstat);
        stim_row_t row;
        row.op          = op;
        row.qid         = qid;
        row.value       = val;
        row.typed       = typed;
        row.want.data   = wdata;
        row.want.status = wstat;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // sender side: optional gap, then hold the word until it is taken
    bit send_burst;

    task automatic send_word(input opcode_t op, input logic [QID_W-1:0] qid,
                             input logic [DATA_W-1:0] val, input bit typed,
                             input result_t want);
        int      gap;
        result_t predicted;
        if ($urandom_range(0, 49) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        // valid only drops when a gap follows, so it is never lowered and
        // raised again in the same step
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_queue_id <= qid;
        s_value    <= val;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        // word taken at this edge
        predicted = predict_queue_op(op, qid, val);
        pending_results.push_back(typed ? want : predicted);
        if (op == OP_ENQ) begin
            n_enq_sent++;
        end else begin
            n_deq_sent++;
        end
    endtask

    // receiver side: per result a random hold-off, plus one long stall
    // that lets the block back up and drop s_ready
    initial begin
        int  gap;
        bit  recv_burst;
        recv_burst = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                recv_burst = !recv_burst;
            end
            if (!long_hold_done && n_results >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                gap = LONG_HOLD;
            end else begin
                gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!m_valid);
        end
    end

    // result checker: every taken result against the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            case (m_status)
                STATUS_OK:    n_ok++;
                STATUS_FULL:  n_full++;
                STATUS_EMPTY: n_empty++;
                default:      ;
            endcase
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result data %h status %0d",
                                          m_data, m_status));
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want.data || m_status !== want.status) begin
                    report_mismatch($sformatf("got data %h status %0d, want data %h status %0d",
                                              m_data, m_status, want.data, want.status));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                       k;
        int                       seg_len;
        int                       enq_pct;
        int                       sent_random;
        bit                       focus;
        logic [QID_W-1:0]         focus_q;
        opcode_t                  op;
        logic [QID_W-1:0]         qid;
        logic [DATA_W-1:0]        val;
        result_t                  none;

        error_count    = 0;
        n_results      = 0;
        n_ok           = 0;
        n_full         = 0;
        n_empty        = 0;
        n_enq_sent     = 0;
        n_deq_sent     = 0;
        long_hold_done = 1'b0;
        send_burst     = 1'b0;
        idle_cycles    = 0;
        none.data      = '0;
        none.status    = STATUS_OK;

        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_opcode   <= OP_ENQ;
        s_queue_id <= '0;
        s_value    <= '0;

        // shadow state after reset: free chain 0..ENTRIES-1, all queues empty
        for (int i = 0; i < ENTRIES; i++) begin
            pool_value[i] = '0;
            pool_link[i]  = LINK_W'(i + 1);
        end
        pool_link[ENTRIES-1] = NULL_LINK;
        for (int i = 0; i < QUEUES; i++) begin
            q_head[i] = NULL_LINK;
            q_tail[i] = '0;
        end
        free_top = '0;

        // directed table
        // empty queue right after reset
        add_row(OP_DEQ, 2'd0, 32'h0, 1'b1, EMPTY_DATA, STATUS_EMPTY);
        // value extremes in and out
        add_row(OP_ENQ, 2'd0, 32'h7fffffff, 1'b1, 32'h0, STATUS_OK);
        add_row(OP_ENQ, 2'd1, 32'h80000000, 1'b1, 32'h0, STATUS_OK);
        add_row(OP_DEQ, 2'd1, 32'h0, 1'b1, 32'h80000000, STATUS_OK);
        add_row(OP_DEQ, 2'd1, 32'hffffffff, 1'b1, EMPTY_DATA, STATUS_EMPTY);
        // use up the rest of the pool over all queues
        for (int i = 0; i < ENTRIES - 1; i++) begin
            case (i % 4)
                0:       val = 32'hffffffff;
                1:       val = 32'haaaaaaaa;
                2:       val = 32'h55555555;
                default: val = 32'(i);
            endcase
            add_row(OP_ENQ, QID_W'(i % QUEUES), val, 1'b0, 32'h0, STATUS_OK);
        end
        // pool exhausted
        add_row(OP_ENQ, 2'd2, 32'h12345678, 1'b1, 32'h0, STATUS_FULL);
        // oldest word of queue 0 comes back first
        add_row(OP_DEQ, 2'd0, 32'h0, 1'b1, 32'h7fffffff, STATUS_OK);
        add_row(OP_DEQ, 2'd3, 32'h0, 1'b0, 32'h0, STATUS_OK);
        add_row(OP_ENQ, 2'd3, 32'h0, 1'b0, 32'h0, STATUS_OK);
        add_row(OP_DEQ, 2'd2, 32'h0, 1'b0, 32'h0, STATUS_OK);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].op, directed_rows[r].qid, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].want);
        end

        // random segments, each with its own enqueue bias so the pool swings
        // between full and drained, sometimes focused on a single queue
        sent_random = 0;
        while (sent_random < RANDOM_WORDS) begin
            case ($urandom_range(0, 4))
                0:       enq_pct = 10;
                1:       enq_pct = 30;
                2:       enq_pct = 50;
                3:       enq_pct = 70;
                default: enq_pct = 90;
            endcase
            focus   = ($urandom_range(0, 1) == 1);
            focus_q = QID_W'($urandom_range(0, QUEUES - 1));
            seg_len = $urandom_range(20, 80);
            for (k = 0; k < seg_len && sent_random < RANDOM_WORDS; k++) begin
                op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                qid = focus ? focus_q : QID_W'($urandom_range(0, QUEUES - 1));
                case ($urandom_range(0, 9))
                    0:       val = 32'h7fffffff;
                    1:       val = 32'h80000000;
                    2:       val = 32'hffffffff;
                    3:       val = 32'h0;
                    default: val = $urandom;
                endcase
                send_word(op, qid, val, 1'b0, none);
                sent_random++;
            end
        end
        s_valid <= 1'b0;

        // drain, then wait another DRAIN_CYCLES to catch any stray result
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("sent %0d enqueue and %0d dequeue words, %0d results checked",
                 n_enq_sent, n_deq_sent, n_results);
        $display("results: %0d ok, %0d pool full, %0d queue empty; long receiver stall %0s",
                 n_ok, n_full, n_empty, long_hold_done ? "done" : "missed");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/smq_pkg.sv
hw/rtl/smq_ram.sv
hw/rtl/smq_link_store.sv
hw/rtl/shared_buffer_multi_queue.sv
tb/tb_shared_buffer_multi_queue.sv
